// ===== sv/pbp_pkg.sv =====
// Package for the page buffer pool: sizes, command and status codes,
// payload structs and the controller/datapath link types. No dependencies.
`default_nettype none

package pbp_pkg;

  localparam int unsigned FRAMES     = 16;
  localparam int unsigned PAGE_BITS  = 20;
  localparam int unsigned PIN_BITS   = 8;
  localparam int unsigned FIDX_W     = $clog2(FRAMES);
  localparam int unsigned CNT_W      = $clog2(FRAMES + 1);

  localparam logic [2:0] CMD_FETCH  = 3'd0;
  localparam logic [2:0] CMD_UNPIN  = 3'd1;
  localparam logic [2:0] CMD_FLUSH  = 3'd2;
  localparam logic [2:0] CMD_NEW    = 3'd3;
  localparam logic [2:0] CMD_DELETE = 3'd4;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NOT_RESIDENT = 3'd1;
  localparam logic [2:0] ST_NOT_PINNED   = 3'd2;
  localparam logic [2:0] ST_NO_FRAME     = 3'd3;
  localparam logic [2:0] ST_DISK_REFUSED = 3'd4;
  localparam logic [2:0] ST_PINNED       = 3'd5;
  localparam logic [2:0] ST_PIN_LIMIT    = 3'd6;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [PAGE_BITS-1:0] page_id;
    logic                 mark_dirty;
    logic                 disk_has_page;
    logic                 alloc_ok;
    logic [PAGE_BITS-1:0] alloc_page_id;
  } in_item_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [FIDX_W-1:0]    frame;
    logic [PAGE_BITS-1:0] result_page;
    logic                 hit;
    logic                 writeback;
    logic [PAGE_BITS-1:0] writeback_page;
    logic                 disk_read;
    logic                 disk_free;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic match;
    logic exec;
  } ctrl_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

// ===== sv/pbp_ctrl.sv =====
// Controller of the page buffer pool: a one-hot sequencer that loads an item,
// runs the tag match and then the update. Depends on pbp_pkg.
`default_nettype none

module pbp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire pbp_pkg::stat_t stat_i,
  output pbp_pkg::ctrl_t     ctrl_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_MATCH = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_MATCH;
        end
      end
      S_MATCH: begin
        ctrl_o.match = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        // The update waits until the output register can take the result.
        if (!stat_i.out_busy) begin
          ctrl_o.exec = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pbp_dpath.sv =====
// Datapath of the page buffer pool: frame table, tag match, free FIFO,
// LRU list and the result register. Depends on pbp_pkg.
`default_nettype none

module pbp_dpath #(
  parameter int unsigned PinBits = pbp_pkg::PIN_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pbp_pkg::ctrl_t     ctrl_i,
  output pbp_pkg::stat_t          stat_o,
  input  wire pbp_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output pbp_pkg::out_item_t      out_data_o
);

  localparam int unsigned Frames = pbp_pkg::FRAMES;
  localparam int unsigned FidxW  = pbp_pkg::FIDX_W;
  localparam int unsigned CntW   = pbp_pkg::CNT_W;
  localparam int unsigned PageW  = pbp_pkg::PAGE_BITS;
  localparam logic [PinBits-1:0] PinMax = '1;

  pbp_pkg::in_item_t  item_q;
  pbp_pkg::out_item_t out_q, res;
  logic               out_valid_q;

  logic [PageW-1:0]   tag_q   [Frames];
  logic [PinBits-1:0] pins_q  [Frames];
  logic [Frames-1:0]  valid_q, dirty_q, in_lru_q, match_q;
  logic [FidxW-1:0]   fifo_q  [Frames];
  logic [FidxW-1:0]   lru_q   [Frames];
  logic [FidxW-1:0]   head_q;
  logic [CntW-1:0]    fcnt_q, lcnt_q;

  // Update controls produced by the execute step.
  logic               fpop_en, fpush_en, lrm_en, lpush_en, emp_en, inst_en;
  logic               pins_en, dirty_en, dirty_val;
  logic [FidxW-1:0]   fpush_f, lrm_f, lpush_f, emp_f, inst_f, pins_f, dirty_f;
  logic [PageW-1:0]   inst_page;
  logic [PinBits-1:0] pins_val;

  logic [PageW-1:0]   key;
  logic [Frames-1:0]  match_d, vict_oh, pos_hit, ge;
  logic [FidxW-1:0]   fidx, vict, head_inc, fpush_idx;
  logic               found, found_x, have_free, have_lru, take_ok;
  logic [CntW:0]      tail_sum;
  logic [CntW-1:0]    fcnt_pop;

  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

  // Match key: the allocated id for a new page, the named page otherwise.
  assign key = (item_q.cmd == pbp_pkg::CMD_NEW) ? item_q.alloc_page_id : item_q.page_id;

  always_comb begin
    for (int i = 0; i < Frames; i++) begin
      match_d[i] = valid_q[i] && (tag_q[i] == key);
    end
  end

  always_comb begin
    fidx = '0;
    for (int i = 0; i < Frames; i++) begin
      if (match_q[i]) begin
        fidx = fidx | FidxW'(i);
      end
    end
  end

  assign found     = |match_q;
  assign have_free = (fcnt_q != '0);
  assign have_lru  = (lcnt_q != '0);
  assign take_ok   = have_free || have_lru;
  assign vict      = have_free ? fifo_q[head_q] : lru_q[0];
  assign vict_oh   = Frames'(1) << vict;
  // The victim is emptied before the allocated id is looked up.
  assign found_x   = |(match_q & ~vict_oh);

  assign head_inc  = (head_q == FidxW'(Frames - 1)) ? '0 : head_q + 1'b1;
  assign tail_sum  = (CntW + 1)'(head_q) + (CntW + 1)'(fcnt_q);
  assign fpush_idx = (tail_sum >= (CntW + 1)'(Frames)) ?
                     FidxW'(tail_sum - (CntW + 1)'(Frames)) : FidxW'(tail_sum);
  assign fcnt_pop  = fcnt_q - CntW'(fpop_en);

  always_comb begin
    res       = '0;
    fpop_en   = 1'b0;
    fpush_en  = 1'b0;
    fpush_f   = vict;
    lrm_en    = 1'b0;
    lrm_f     = fidx;
    lpush_en  = 1'b0;
    lpush_f   = fidx;
    emp_en    = 1'b0;
    emp_f     = fidx;
    inst_en   = 1'b0;
    inst_f    = vict;
    inst_page = item_q.page_id;
    pins_en   = 1'b0;
    pins_f    = fidx;
    pins_val  = pins_q[fidx];
    dirty_en  = 1'b0;
    dirty_f   = fidx;
    dirty_val = 1'b0;
    unique case (item_q.cmd)
      pbp_pkg::CMD_FETCH, pbp_pkg::CMD_NEW: begin
        if ((item_q.cmd == pbp_pkg::CMD_FETCH) && found) begin
          res.frame       = fidx;
          res.result_page = item_q.page_id;
          res.hit         = 1'b1;
          if (pins_q[fidx] == PinMax) begin
            res.status = pbp_pkg::ST_PIN_LIMIT;
          end else begin
            pins_en  = 1'b1;
            pins_val = pins_q[fidx] + 1'b1;
            lrm_en   = in_lru_q[fidx];
          end
        end else if (!take_ok) begin
          res.status = pbp_pkg::ST_NO_FRAME;
        end else begin
          fpop_en = have_free;
          lrm_en  = !have_free;
          lrm_f   = vict;
          emp_en  = 1'b1;
          emp_f   = vict;
          res.frame = vict;
          if (valid_q[vict] && dirty_q[vict]) begin
            res.writeback      = 1'b1;
            res.writeback_page = tag_q[vict];
          end
          if (item_q.cmd == pbp_pkg::CMD_FETCH) begin
            if (!item_q.disk_has_page) begin
              fpush_en   = 1'b1;
              res.status = pbp_pkg::ST_DISK_REFUSED;
            end else begin
              inst_en         = 1'b1;
              res.result_page = item_q.page_id;
              res.disk_read   = 1'b1;
            end
          end else begin
            if (!item_q.alloc_ok || found_x) begin
              fpush_en   = 1'b1;
              res.status = pbp_pkg::ST_DISK_REFUSED;
            end else begin
              inst_en         = 1'b1;
              inst_page       = item_q.alloc_page_id;
              res.result_page = item_q.alloc_page_id;
            end
          end
        end
      end
      pbp_pkg::CMD_UNPIN: begin
        if (!found) begin
          res.status = pbp_pkg::ST_NOT_RESIDENT;
        end else begin
          res.frame       = fidx;
          res.result_page = item_q.page_id;
          if (pins_q[fidx] == '0) begin
            res.status = pbp_pkg::ST_NOT_PINNED;
          end else begin
            pins_en   = 1'b1;
            pins_val  = pins_q[fidx] - 1'b1;
            dirty_en  = 1'b1;
            dirty_val = dirty_q[fidx] | item_q.mark_dirty;
            lpush_en  = (pins_q[fidx] == PinBits'(1)) && !in_lru_q[fidx];
          end
        end
      end
      pbp_pkg::CMD_FLUSH: begin
        if (!found) begin
          res.status = pbp_pkg::ST_NOT_RESIDENT;
        end else begin
          res.frame          = fidx;
          res.result_page    = item_q.page_id;
          res.writeback      = 1'b1;
          res.writeback_page = item_q.page_id;
          dirty_en           = 1'b1;
        end
      end
      pbp_pkg::CMD_DELETE: begin
        if (!found) begin
          res.disk_free = 1'b1;
        end else begin
          res.frame       = fidx;
          res.result_page = item_q.page_id;
          if (pins_q[fidx] != '0) begin
            res.status = pbp_pkg::ST_PINNED;
          end else begin
            lrm_en        = in_lru_q[fidx];
            emp_en        = 1'b1;
            fpush_en      = 1'b1;
            fpush_f       = fidx;
            res.disk_free = 1'b1;
          end
        end
      end
      default: res = '0;
    endcase
  end

  // Removal from the LRU list closes the gap by shifting the later entries down.
  always_comb begin
    for (int j = 0; j < Frames; j++) begin
      pos_hit[j] = (lru_q[j] == lrm_f) && (CntW'(j) < lcnt_q);
    end
    ge[0] = pos_hit[0];
    for (int j = 1; j < Frames; j++) begin
      ge[j] = ge[j-1] | pos_hit[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      item_q <= in_data_i;
    end
    if (ctrl_i.exec) begin
      out_q <= res;
      if (inst_en) begin
        tag_q[inst_f] <= inst_page;
      end
      if (lrm_en) begin
        for (int j = 0; j < Frames - 1; j++) begin
          if (ge[j]) begin
            lru_q[j] <= lru_q[j+1];
          end
        end
      end
      if (lpush_en && (lcnt_q != CntW'(Frames))) begin
        lru_q[lcnt_q[FidxW-1:0]] <= lpush_f;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      match_q     <= '0;
      valid_q     <= '0;
      dirty_q     <= '0;
      in_lru_q    <= '0;
      head_q      <= '0;
      fcnt_q      <= CntW'(Frames);
      lcnt_q      <= '0;
      for (int i = 0; i < Frames; i++) begin
        pins_q[i] <= '0;
        fifo_q[i] <= FidxW'(i);
      end
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (ctrl_i.match) begin
        match_q <= match_d;
      end
      if (ctrl_i.exec) begin
        out_valid_q <= 1'b1;
        if (emp_en) begin
          valid_q[emp_f] <= 1'b0;
          dirty_q[emp_f] <= 1'b0;
          pins_q[emp_f]  <= '0;
        end
        if (inst_en) begin
          valid_q[inst_f] <= 1'b1;
          dirty_q[inst_f] <= 1'b0;
          pins_q[inst_f]  <= PinBits'(1);
        end
        if (pins_en) begin
          pins_q[pins_f] <= pins_val;
        end
        if (dirty_en) begin
          dirty_q[dirty_f] <= dirty_val;
        end
        if (fpop_en) begin
          head_q <= head_inc;
        end
        if (fpush_en && (fcnt_pop != CntW'(Frames))) begin
          fifo_q[fpush_idx] <= fpush_f;
          fcnt_q            <= fcnt_pop + 1'b1;
        end else begin
          fcnt_q <= fcnt_pop;
        end
        if (lrm_en) begin
          in_lru_q[lrm_f] <= 1'b0;
          lcnt_q          <= lcnt_q - 1'b1;
        end else if (lpush_en && (lcnt_q != CntW'(Frames))) begin
          in_lru_q[lpush_f] <= 1'b1;
          lcnt_q            <= lcnt_q + 1'b1;
        end
      end
    end
  end

  a_match_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_q))
    else $error("more than one frame matched the key");

  a_lru_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(in_lru_q) == 32'(lcnt_q))
    else $error("LRU count disagrees with LRU membership");

  a_lru_unpinned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_lru_q & ~valid_q) == '0)
    else $error("an empty frame sits in the LRU list");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(fcnt_q) + 32'(lcnt_q)) <= Frames)
    else $error("free and LRU counts exceed the pool");

endmodule

`default_nettype wire

// ===== sv/page_buffer_pool_lru.sv =====
// Top level of the page buffer pool with LRU replacement: joins the
// controller and the datapath. Depends on pbp_pkg, pbp_ctrl and pbp_dpath.
//
//   channel | direction | handshake                | beat
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (pbp_pkg::in_item_t)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (pbp_pkg::out_item_t)
//
// An item passes through load, parallel tag match, then update and result.
// The next item is taken while the result still waits in the output register.
// The update step stalls while an earlier result has not been taken.
// Reset empties every frame and fills the free FIFO with frames in order.
`default_nettype none

module page_buffer_pool_lru #(
  parameter int unsigned PinBits = pbp_pkg::PIN_BITS
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire pbp_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output pbp_pkg::out_item_t      out_data_o
);

  pbp_pkg::ctrl_t ctrl;
  pbp_pkg::stat_t stat;

  pbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  pbp_dpath #(
    .PinBits (PinBits)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_page_buffer_pool_lru.sv =====
// Self-checking testbench for page_buffer_pool_lru: predicts every result beat
// from its own model of the frame table, free FIFO and LRU order.
// Depends on pbp_pkg and the page_buffer_pool_lru RTL.
`timescale 1ns / 100ps

module tb_page_buffer_pool_lru;

  localparam int unsigned FRAMES = pbp_pkg::FRAMES;
  localparam int unsigned PAGE_W = pbp_pkg::PAGE_BITS;
  localparam int unsigned PIN_W  = pbp_pkg::PIN_BITS;
  localparam int unsigned FIDX_W = pbp_pkg::FIDX_W;
  localparam logic [PIN_W-1:0] PIN_LIMIT = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o;
  pbp_pkg::in_item_t in_data_i = '0;
  pbp_pkg::out_item_t out_data_o;

  page_buffer_pool_lru dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state for the pool.
  logic [PAGE_W-1:0] pool_tag [FRAMES];
  logic              pool_valid [FRAMES];
  logic [PIN_W-1:0]  pool_pins [FRAMES];
  logic              pool_dirty [FRAMES];
  int                free_q [$];
  int                lru_q [$];

  pbp_pkg::in_item_t  pending_cmds [$];
  pbp_pkg::out_item_t expected_beats [$];
  int mismatches = 0;
  int beats_seen = 0;
  int sent = 0;
  int evictions = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  function automatic int lookup_frame(logic [PAGE_W-1:0] page);
    for (int i = 0; i < FRAMES; i++)
      if (pool_valid[i] && pool_tag[i] == page) return i;
    return -1;
  endfunction

  function automatic void drop_lru(int f);
    foreach (lru_q[i])
      if (lru_q[i] == f) begin
        lru_q.delete(i);
        return;
      end
  endfunction

  function automatic void clear_frame(int f);
    pool_valid[f] = 1'b0;
    pool_pins[f] = '0;
    pool_dirty[f] = 1'b0;
    pool_tag[f] = '0;
  endfunction

  // Claims a frame from the free FIFO, else evicts the LRU head.
  function automatic int claim_frame(inout pbp_pkg::out_item_t r);
    int v;
    if (free_q.size() > 0) v = free_q.pop_front();
    else if (lru_q.size() > 0) begin
      v = lru_q.pop_front();
      evictions++;
    end else return -1;
    if (pool_valid[v] && pool_dirty[v]) begin
      r.writeback = 1'b1;
      r.writeback_page = pool_tag[v];
    end
    clear_frame(v);
    return v;
  endfunction

  function automatic void load_frame(int f, logic [PAGE_W-1:0] page);
    pool_tag[f] = page;
    pool_valid[f] = 1'b1;
    pool_pins[f] = PIN_W'(1);
    pool_dirty[f] = 1'b0;
  endfunction

  function automatic pbp_pkg::out_item_t predict_pool(pbp_pkg::in_item_t c);
    pbp_pkg::out_item_t r = '0;
    int k;
    case (c.cmd)
      pbp_pkg::CMD_FETCH: begin
        k = lookup_frame(c.page_id);
        if (k >= 0) begin
          r.frame = FIDX_W'(k);
          r.result_page = c.page_id;
          r.hit = 1'b1;
          if (pool_pins[k] == PIN_LIMIT) r.status = pbp_pkg::ST_PIN_LIMIT;
          else begin
            pool_pins[k]++;
            drop_lru(k);
          end
        end else begin
          k = claim_frame(r);
          if (k < 0) r.status = pbp_pkg::ST_NO_FRAME;
          else begin
            r.frame = FIDX_W'(k);
            if (!c.disk_has_page) begin
              free_q.insert(free_q.size(), k);
              r.status = pbp_pkg::ST_DISK_REFUSED;
            end else begin
              load_frame(k, c.page_id);
              r.result_page = c.page_id;
              r.disk_read = 1'b1;
            end
          end
        end
      end
      pbp_pkg::CMD_UNPIN: begin
        k = lookup_frame(c.page_id);
        if (k < 0) r.status = pbp_pkg::ST_NOT_RESIDENT;
        else begin
          r.frame = FIDX_W'(k);
          r.result_page = c.page_id;
          if (pool_pins[k] == 0) r.status = pbp_pkg::ST_NOT_PINNED;
          else begin
            pool_pins[k]--;
            if (c.mark_dirty) pool_dirty[k] = 1'b1;
            if (pool_pins[k] == 0) lru_q.insert(lru_q.size(), k);
          end
        end
      end
      pbp_pkg::CMD_FLUSH: begin
        k = lookup_frame(c.page_id);
        if (k < 0) r.status = pbp_pkg::ST_NOT_RESIDENT;
        else begin
          r.frame = FIDX_W'(k);
          r.result_page = c.page_id;
          r.writeback = 1'b1;
          r.writeback_page = c.page_id;
          pool_dirty[k] = 1'b0;
        end
      end
      pbp_pkg::CMD_NEW: begin
        k = claim_frame(r);
        if (k < 0) r.status = pbp_pkg::ST_NO_FRAME;
        else begin
          r.frame = FIDX_W'(k);
          if (!c.alloc_ok || lookup_frame(c.alloc_page_id) >= 0) begin
            free_q.insert(free_q.size(), k);
            r.status = pbp_pkg::ST_DISK_REFUSED;
          end else begin
            load_frame(k, c.alloc_page_id);
            r.result_page = c.alloc_page_id;
          end
        end
      end
      pbp_pkg::CMD_DELETE: begin
        k = lookup_frame(c.page_id);
        if (k < 0) r.disk_free = 1'b1;
        else begin
          r.frame = FIDX_W'(k);
          r.result_page = c.page_id;
          if (pool_pins[k] > 0) r.status = pbp_pkg::ST_PINNED;
          else begin
            drop_lru(k);
            clear_frame(k);
            free_q.insert(free_q.size(), k);
            r.disk_free = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Driver: a beat is offered at random and held until taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        expected_beats.insert(expected_beats.size(), predict_pool(in_data_i));
        sent++;
      end
      if ((!in_valid_i || in_ready_o) && pending_cmds.size() > 0
          && (quiet || $urandom_range(99) >= 23)) begin
        in_data_i <= pending_cmds.pop_front();
        in_valid_i <= 1'b1;
      end else if (!in_valid_i || in_ready_o) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: compares each result beat with the oldest prediction.
  always @(posedge clk_i) begin
    pbp_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        beats_seen++;
        if (expected_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result beat %p", out_data_o);
        end else begin
          want = expected_beats.pop_front();
          if (out_data_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch at beat %0d: expected %p, got %p",
                       beats_seen, want, out_data_o);
          end
        end
      end
      out_ready_i <= !hold_off && (quiet || $urandom_range(99) >= 23);
    end
  end

  function automatic pbp_pkg::in_item_t make_cmd(logic [2:0] cmd, logic [PAGE_W-1:0] page);
    pbp_pkg::in_item_t c;
    c.cmd = cmd;
    c.page_id = page;
    c.mark_dirty = 1'($urandom_range(1));
    c.disk_has_page = 1'b1;
    c.alloc_ok = 1'b1;
    c.alloc_page_id = PAGE_W'($urandom);
    return c;
  endfunction

  // Draws pages from a small pool so hits, evictions and clashes are common,
  // with occasional full-width values.
  function automatic logic [PAGE_W-1:0] pick_page();
    if ($urandom_range(9) == 0) return PAGE_W'($urandom);
    return PAGE_W'($urandom_range(23)) ^ ($urandom_range(1) ? {PAGE_W{1'b1}} : '0);
  endfunction

  initial begin
    pbp_pkg::in_item_t c;
    int roll;
    for (int i = 0; i < FRAMES; i++) begin
      clear_frame(i);
      free_q.insert(free_q.size(), i);
    end
    // Directed: extremes, every command and the corner cases.
    c = make_cmd(pbp_pkg::CMD_DELETE, '1);  pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(pbp_pkg::CMD_UNPIN, '0);   pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(pbp_pkg::CMD_FLUSH, '1);   pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(pbp_pkg::CMD_FETCH, '0); c.disk_has_page = 1'b0;
    pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(pbp_pkg::CMD_FETCH, '1);   pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(pbp_pkg::CMD_FETCH, '1);   pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(pbp_pkg::CMD_DELETE, '1);  pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(pbp_pkg::CMD_UNPIN, '1); c.mark_dirty = 1'b1;
    pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(pbp_pkg::CMD_UNPIN, '1);   pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(pbp_pkg::CMD_UNPIN, '1);   pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(pbp_pkg::CMD_FLUSH, '1);   pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(pbp_pkg::CMD_NEW, '0); c.alloc_ok = 1'b0;
    pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(pbp_pkg::CMD_NEW, '0); c.alloc_page_id = '1;
    pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(pbp_pkg::CMD_NEW, '0); c.alloc_page_id = '0;
    pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(pbp_pkg::CMD_DELETE, '0);  pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(3'd5, '1);                 pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(3'd7, '0); c.alloc_page_id = '1;
    pending_cmds.insert(pending_cmds.size(), c);
    // Fill every frame with pinned pages so the pool runs out.
    for (int i = 1; i < FRAMES; i++) begin
      c = make_cmd(pbp_pkg::CMD_FETCH, PAGE_W'(100 + i));
      pending_cmds.insert(pending_cmds.size(), c);
    end
    c = make_cmd(pbp_pkg::CMD_NEW, '0);     pending_cmds.insert(pending_cmds.size(), c);
    c = make_cmd(pbp_pkg::CMD_DELETE, PAGE_W'(101));
    pending_cmds.insert(pending_cmds.size(), c);
    // Pin one page to the limit and past it, then release it and unpin it once more.
    for (int i = 0; i < 256; i++) begin
      c = make_cmd(pbp_pkg::CMD_FETCH, PAGE_W'(102));
      pending_cmds.insert(pending_cmds.size(), c);
    end
    for (int i = 0; i < 256; i++) begin
      c = make_cmd(pbp_pkg::CMD_UNPIN, PAGE_W'(102));
      pending_cmds.insert(pending_cmds.size(), c);
    end
    for (int i = 0; i < 1150; i++) begin
      roll = $urandom_range(99);
      c = make_cmd(roll < 40 ? pbp_pkg::CMD_FETCH : roll < 70 ? pbp_pkg::CMD_UNPIN :
                   roll < 78 ? pbp_pkg::CMD_FLUSH : roll < 88 ? pbp_pkg::CMD_NEW :
                   roll < 98 ? pbp_pkg::CMD_DELETE : 3'($urandom_range(5, 7)),
                   pick_page());
      c.disk_has_page = $urandom_range(9) != 0;
      c.alloc_ok = $urandom_range(9) != 0;
      c.alloc_page_id = $urandom_range(3) == 0 ? pick_page() : PAGE_W'($urandom);
      pending_cmds.insert(pending_cmds.size(), c);
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Pressure and quiet stretches, counted here in cycles.
  initial begin
    wait (rst_ni);
    repeat (600) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
    repeat (1000) @(posedge clk_i);
    quiet = 1'b1;
    repeat (800) @(posedge clk_i);
    quiet = 1'b0;
  end

  initial begin
    wait (rst_ni);
    wait (pending_cmds.size() == 0 && !in_valid_i);
    wait (expected_beats.size() == 0);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d commands and %0d result beats, with %0d LRU evictions.",
             sent, beats_seen, evictions);
    if (mismatches == 0 && expected_beats.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out with %0d results outstanding", expected_beats.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
